FILE: rtl/core/enclosure_climate_controller_defines.svh
// assertion macros for the enclosure climate controller checker
// included by ecc_checker.sv; needs i_clk and i_rst_n in the including scope
`ifndef ENCLOSURE_CLIMATE_CONTROLLER_DEFINES_SVH
`define ENCLOSURE_CLIMATE_CONTROLLER_DEFINES_SVH

// checked only outside reset
`define ECC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ECC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/ecc_pkg.sv
// shared types and constants of the enclosure climate controller
// no dependencies; imported by the top level, the checker and the bench
`timescale 1ns / 1ps

package ecc_pkg;

    // climate mode codes as they appear on the result word
    typedef enum logic [1:0] {
        MODE_FAN     = 2'd0,
        MODE_NATURAL = 2'd1,
        MODE_HEAT    = 2'd2
    } t_climate_mode;

    // remote uv command codes
    typedef enum logic [1:0] {
        UV_CMD_NONE   = 2'd0,
        UV_CMD_ON     = 2'd1,
        UV_CMD_OFF    = 2'd2,
        UV_CMD_TOGGLE = 2'd3
    } t_uv_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_LOW  = 3'd0,
        CFG_TARGET_HIGH = 3'd1,
        CFG_DANGER      = 3'd2,
        CFG_DEAD_BAND   = 3'd3,
        CFG_PERIOD      = 3'd4,
        CFG_LOCKOUT     = 3'd5
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TEMP_W     = 13;
    localparam int unsigned DEG_W      = 7;
    localparam int unsigned BAND_W     = 8;
    localparam int unsigned TICK_W     = 16;

    // register reset values
    localparam logic [DEG_W-1:0]         RST_TARGET_LOW  = 7'd20;
    localparam logic [DEG_W-1:0]         RST_TARGET_HIGH = 7'd35;
    localparam logic signed [TEMP_W-1:0] RST_DANGER      = 13'sd640;
    localparam logic [BAND_W-1:0]        RST_DEAD_BAND   = 8'd16;
    localparam logic [TICK_W-1:0]        RST_PERIOD      = 16'd3000;
    localparam logic [TICK_W-1:0]        RST_LOCKOUT     = 16'd300;

    // state reset values
    localparam logic [DEG_W-1:0] RST_TARGET = 7'd25;
    localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;

endpackage

FILE: rtl/core/ecc_in_if.sv
// input channel of the enclosure climate controller: one tick word
// standalone; valid/ready handshake plus the tick fields
`timescale 1ns / 1ps

interface ecc_in_if;
    logic              valid;
    logic              ready;
    logic              in_setting_mode;
    logic              up_pressed;
    logic              down_pressed;
    logic              uv_switch;
    logic signed [12:0] temperature;
    logic        [1:0] func;

    modport source (
        output valid, in_setting_mode, up_pressed, down_pressed, uv_switch,
               temperature, func,
        input  ready
    );

    modport sink (
        input  valid, in_setting_mode, up_pressed, down_pressed, uv_switch,
               temperature, func,
        output ready
    );
endinterface

FILE: rtl/core/ecc_out_if.sv
// output channel of the enclosure climate controller: one result word per tick
// standalone; valid/ready handshake plus the result fields
`timescale 1ns / 1ps

interface ecc_out_if;
    logic               valid;
    logic               ready;
    logic               heater_on;
    logic               fan_on;
    logic               uv_on;
    logic        [1:0]  climate_mode;
    logic        [6:0]  target_degrees;
    logic signed [12:0] last_temperature;
    logic               decided;

    modport source (
        output valid, heater_on, fan_on, uv_on, climate_mode, target_degrees,
               last_temperature, decided,
        input  ready
    );

    modport sink (
        input  valid, heater_on, fan_on, uv_on, climate_mode, target_degrees,
               last_temperature, decided,
        output ready
    );
endinterface

FILE: rtl/core/enclosure_climate_controller.sv
// Enclosure climate controller: hysteresis thermostat, target buttons and uv lamp
// control. Each input word is one millisecond tick and yields exactly one result word.
// One word is accepted per clock while the result side is not stalled. Its result passes
// from the input register into the result register, where the sink can take it.
// Throughput is set by the single update of the controller state between those two
// registers. Result backpressure stalls the input register, which in turn drops
// i_in.ready. Configuration must be written through i_cfg_we/i_cfg_idx/i_cfg_data only
// while no word is in flight; the block itself does not enforce this. Indexes beyond the
// register list are ignored. Depends on ecc_pkg, ecc_in_if and ecc_out_if.
`timescale 1ns / 1ps

module enclosure_climate_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ecc_in_if.sink                              i_in,
    ecc_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [ecc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ecc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ecc_pkg::*;

    // ---------------- configuration registers ----------------
    logic        [DEG_W-1:0]  r_target_low;
    logic        [DEG_W-1:0]  r_target_high;
    logic signed [TEMP_W-1:0] r_danger;
    logic        [BAND_W-1:0] r_dead_band;
    logic        [TICK_W-1:0] r_period;
    logic        [TICK_W-1:0] r_lockout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_low  <= RST_TARGET_LOW;
            r_target_high <= RST_TARGET_HIGH;
            r_danger      <= RST_DANGER;
            r_dead_band   <= RST_DEAD_BAND;
            r_period      <= RST_PERIOD;
            r_lockout     <= RST_LOCKOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_LOW:  r_target_low  <= i_cfg_data[DEG_W-1:0];
                CFG_TARGET_HIGH: r_target_high <= i_cfg_data[DEG_W-1:0];
                CFG_DANGER:      r_danger      <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_DEAD_BAND:   r_dead_band   <= i_cfg_data[BAND_W-1:0];
                CFG_PERIOD:      r_period      <= i_cfg_data[TICK_W-1:0];
                CFG_LOCKOUT:     r_lockout     <= i_cfg_data[TICK_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;   // result register can take a word this cycle
    logic w_adv;        // input register moves into the result register

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    // ---------------- input register ----------------
    logic               r_in_setting;
    logic               r_in_up;
    logic               r_in_down;
    logic               r_in_sw;
    logic signed [TEMP_W-1:0] r_in_temp;
    t_uv_cmd            r_in_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_setting <= i_in.in_setting_mode;
            r_in_up      <= i_in.up_pressed;
            r_in_down    <= i_in.down_pressed;
            r_in_sw      <= i_in.uv_switch;
            r_in_temp    <= i_in.temperature;
            r_in_func    <= t_uv_cmd'(i_in.func);
        end
    end

    // ---------------- controller state ----------------
    logic        [DEG_W-1:0]  r_target, n_target;
    t_climate_mode            r_mode, n_mode;
    logic                     r_armed, n_armed;
    logic        [TICK_W-1:0] r_lock_cnt, n_lock_cnt;
    logic        [TICK_W-1:0] r_per_cnt, n_per_cnt;
    logic                     r_per_run, n_per_run;
    logic                     r_rem_act, n_rem_act;
    logic                     r_rem_uv, n_rem_uv;
    logic signed [TEMP_W-1:0] r_held, n_held;

    // per-tick decode
    logic                     w_uv;
    logic                     w_decide;
    logic                     w_rem_act_cmd;   // remote state after the command
    logic                     w_rem_uv_cmd;
    logic        [TICK_W-1:0] w_lock_inc;
    logic signed [TEMP_W:0]   w_t16;           // target in sixteenths
    logic signed [TEMP_W:0]   w_band;
    logic signed [TEMP_W:0]   w_temp_x;
    logic signed [TEMP_W:0]   w_danger_x;

    // compare operands sign-extended by one bit: target*16 +/- band spans -255..2287
    assign w_t16      = $signed({3'b000, r_target, 4'b0000});
    assign w_band     = $signed({{(TEMP_W+1-BAND_W){1'b0}}, r_dead_band});
    assign w_temp_x   = {r_in_temp[TEMP_W-1], r_in_temp};
    assign w_danger_x = {r_danger[TEMP_W-1], r_danger};
    assign w_lock_inc = (r_lock_cnt == TICK_MAX) ? r_lock_cnt : r_lock_cnt + 1'b1;

    always_comb begin
        n_target   = r_target;
        n_mode     = r_mode;
        n_armed    = r_armed;
        n_per_cnt  = r_per_cnt;
        n_per_run  = r_per_run;
        n_held     = r_held;
        n_lock_cnt = w_lock_inc;
        w_decide   = 1'b0;

        // remote command is applied before anything else
        unique case (r_in_func)
            UV_CMD_NONE: begin
                w_rem_act_cmd = r_rem_act;
                w_rem_uv_cmd  = r_rem_uv;
            end
            UV_CMD_ON: begin
                w_rem_act_cmd = 1'b1;
                w_rem_uv_cmd  = 1'b1;
            end
            UV_CMD_OFF: begin
                w_rem_act_cmd = 1'b1;
                w_rem_uv_cmd  = 1'b0;
            end
            UV_CMD_TOGGLE: begin
                w_rem_act_cmd = 1'b1;
                w_rem_uv_cmd  = !r_rem_uv;
            end
            default: begin
                w_rem_act_cmd = r_rem_act;
                w_rem_uv_cmd  = r_rem_uv;
            end
        endcase

        // lamp follows remote flag on this tick even if setting mode drops remote
        w_uv      = w_rem_act_cmd ? w_rem_uv_cmd : r_in_sw;
        n_rem_uv  = w_rem_uv_cmd;
        n_rem_act = w_rem_act_cmd;

        if (!r_in_setting) begin
            // operating mode: period timer restarts on the first tick and after a decision
            if (!r_per_run) begin
                n_per_run = 1'b1;
                n_per_cnt = '0;
            end else begin
                n_per_cnt = (r_per_cnt == TICK_MAX) ? r_per_cnt : r_per_cnt + 1'b1;
            end
            if (n_per_cnt >= r_period) begin
                w_decide  = 1'b1;
                n_per_cnt = '0;
                n_held    = r_in_temp;
                priority if (w_temp_x > w_danger_x) begin
                    n_mode = MODE_FAN;
                end else if (w_temp_x > w_t16 + w_band) begin
                    n_mode = MODE_NATURAL;
                end else if (w_temp_x > w_t16 - w_band) begin
                    n_mode = r_mode;    // inside hold band
                end else begin
                    n_mode = MODE_HEAT;
                end
            end
        end else begin
            // setting mode: remote off, timer stopped, buttons step the target
            n_rem_act = 1'b0;
            n_per_run = 1'b0;
            if (r_armed) begin
                priority if (r_in_up) begin
                    n_armed    = 1'b0;
                    n_lock_cnt = '0;
                    if (r_target < r_target_high) begin
                        n_target = r_target + 1'b1;
                    end
                end else if (r_in_down) begin
                    n_armed    = 1'b0;
                    n_lock_cnt = '0;
                    if (r_target > r_target_low) begin
                        n_target = r_target - 1'b1;
                    end
                end else begin
                    n_armed = r_armed;
                end
            end else if (w_lock_inc >= r_lockout) begin
                n_armed = 1'b1;   // re-arm only, no step on this tick
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= RST_TARGET;
            r_mode     <= MODE_NATURAL;
            r_armed    <= 1'b1;
            r_lock_cnt <= '0;
            r_per_cnt  <= '0;
            r_per_run  <= 1'b0;
            r_rem_act  <= 1'b0;
            r_rem_uv   <= 1'b0;
            r_held     <= '0;
        end else if (w_adv) begin
            r_target   <= n_target;
            r_mode     <= n_mode;
            r_armed    <= n_armed;
            r_lock_cnt <= n_lock_cnt;
            r_per_cnt  <= n_per_cnt;
            r_per_run  <= n_per_run;
            r_rem_act  <= n_rem_act;
            r_rem_uv   <= n_rem_uv;
            r_held     <= n_held;
        end
    end

    // ---------------- result register ----------------
    logic               r_out_heater;
    logic               r_out_fan;
    logic               r_out_uv;
    t_climate_mode      r_out_mode;
    logic [DEG_W-1:0]   r_out_target;
    logic signed [TEMP_W-1:0] r_out_held;
    logic               r_out_decided;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_heater  <= (n_mode == MODE_HEAT);
            r_out_fan     <= (n_mode == MODE_FAN);
            r_out_uv      <= w_uv;
            r_out_mode    <= n_mode;
            r_out_target  <= n_target;
            r_out_held    <= n_held;
            r_out_decided <= w_decide;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.heater_on        = r_out_heater;
    assign o_out.fan_on           = r_out_fan;
    assign o_out.uv_on            = r_out_uv;
    assign o_out.climate_mode     = r_out_mode;
    assign o_out.target_degrees   = r_out_target;
    assign o_out.last_temperature = r_out_held;
    assign o_out.decided          = r_out_decided;

endmodule

FILE: rtl/core/ecc_checker.sv
// port-level checks of the enclosure climate controller, bound to the top level
// depends on ecc_pkg and enclosure_climate_controller_defines.svh
`timescale 1ns / 1ps
`include "enclosure_climate_controller_defines.svh"

module ecc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_heater_on,
    input logic       i_fan_on,
    input logic [1:0] i_climate_mode
);
    import ecc_pkg::*;

    // result word waits until taken
    `ECC_ASSERT_RUN(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")

    // nothing comes out in the cycle after reset
    `ECC_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "result word right after reset")

    // drives agree with the reported mode
    `ECC_ASSERT_RUN(a_drive_mode, i_out_valid |-> (i_heater_on == (i_climate_mode == MODE_HEAT)) && (i_fan_on == (i_climate_mode == MODE_FAN)), "heater or fan disagrees with climate mode")

    // heater and fan never run together
    `ECC_ASSERT_RUN(a_no_fight, i_out_valid |-> !(i_heater_on && i_fan_on), "heater and fan both on")

endmodule

bind enclosure_climate_controller ecc_checker u_ecc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_heater_on    (o_out.heater_on),
    .i_fan_on       (o_out.fan_on),
    .i_climate_mode (o_out.climate_mode)
);

FILE: bench/enclosure_climate_controller_tb.sv
// self-checking bench for the enclosure climate controller: thermostat, target buttons, uv lamp
// needs ecc_pkg, ecc_in_if, ecc_out_if and the enclosure_climate_controller top level
`timescale 1ns / 1ps

module enclosure_climate_controller_tb;
    import ecc_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CHUNKS        = 5;
    localparam int CHUNK_WORDS   = 107;
    localparam int LONG_RUN      = 32;

    // one tick word as the sender sees it
    typedef struct packed {
        logic                      setting;
        logic                      up;
        logic                      down;
        logic                      uv_sw;
        logic signed [TEMP_W-1:0]  temp;
        t_uv_cmd                   cmd;
    } t_tick;

    // one result word as the thermostat should drive it
    typedef struct packed {
        logic                      heater;
        logic                      fan;
        logic                      uv;
        t_climate_mode             mode;
        logic [DEG_W-1:0]          target;
        logic signed [TEMP_W-1:0]  held;
        logic                      decided;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ecc_in_if  in_ch ();
    ecc_out_if out_ch ();

    enclosure_climate_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock, first rising edge at 2 ns
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies kept by the bench
    logic [DEG_W-1:0]         cfg_lo;
    logic [DEG_W-1:0]         cfg_hi;
    logic signed [TEMP_W-1:0] cfg_danger;
    logic [BAND_W-1:0]        cfg_band;
    logic [TICK_W-1:0]        cfg_period;
    logic [TICK_W-1:0]        cfg_lockout;

    // thermostat state as the bench tracks it
    logic [DEG_W-1:0]         target_deg;
    t_climate_mode            climate;
    logic                     armed;
    logic [TICK_W-1:0]        press_age;
    logic [TICK_W-1:0]        since_decision;
    logic                     timer_live;
    logic                     remote_on;
    logic                     remote_lamp;
    logic signed [TEMP_W-1:0] latched_temp;

    // results still owed by the block, oldest first
    t_drive awaited_drive[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int decisions_made = 0;
    int presses_taken = 0;
    int uv_commands = 0;
    logic gen_setting = 1'b0;

    function automatic logic [TICK_W-1:0] sat_tick(logic [TICK_W-1:0] v);
        return (v == TICK_MAX) ? v : v + 1'b1;
    endfunction

    task automatic reset_thermostat();
        cfg_lo = RST_TARGET_LOW;
        cfg_hi = RST_TARGET_HIGH;
        cfg_danger = RST_DANGER;
        cfg_band = RST_DEAD_BAND;
        cfg_period = RST_PERIOD;
        cfg_lockout = RST_LOCKOUT;
        target_deg = RST_TARGET;
        climate = MODE_NATURAL;
        armed = 1'b1;
        press_age = '0;
        since_decision = '0;
        timer_live = 1'b0;
        remote_on = 1'b0;
        remote_lamp = 1'b0;
        latched_temp = '0;
    endtask

    // advances the tracked state by one tick and returns the result it must produce
    function automatic t_drive climate_step(t_tick w);
        t_drive r;
        logic lamp;
        int temp_now;
        int setpoint;
        int band;
        r.decided = 1'b0;
        temp_now = int'(w.temp);
        // remote command comes first, before the lamp is chosen
        case (w.cmd)
            UV_CMD_ON: begin
                remote_on = 1'b1;
                remote_lamp = 1'b1;
            end
            UV_CMD_OFF: begin
                remote_on = 1'b1;
                remote_lamp = 1'b0;
            end
            UV_CMD_TOGGLE: begin
                remote_on = 1'b1;
                remote_lamp = !remote_lamp;
            end
            default: ;
        endcase
        if (w.cmd != UV_CMD_NONE) uv_commands++;
        lamp = remote_on ? remote_lamp : w.uv_sw;
        press_age = sat_tick(press_age);
        if (!w.setting) begin
            // first operating tick only starts the period timer
            if (!timer_live) begin
                timer_live = 1'b1;
                since_decision = '0;
            end else begin
                since_decision = sat_tick(since_decision);
            end
            if (since_decision >= cfg_period) begin
                setpoint = int'(target_deg) * 16;
                band = int'(cfg_band);
                since_decision = '0;
                r.decided = 1'b1;
                latched_temp = w.temp;
                decisions_made++;
                if (temp_now > int'(cfg_danger)) climate = MODE_FAN;
                else if (temp_now > setpoint + band) climate = MODE_NATURAL;
                else if (temp_now <= setpoint - band) climate = MODE_HEAT;
                // inside the band the previous mode is kept
            end
        end else begin
            // setting mode drops remote control and stops the timer
            remote_on = 1'b0;
            timer_live = 1'b0;
            if (armed) begin
                if (w.up || w.down) begin
                    armed = 1'b0;
                    press_age = '0;
                    presses_taken++;
                    // up wins when both are held
                    if (w.up) begin
                        if (target_deg < cfg_hi) target_deg = target_deg + 1'b1;
                    end else if (target_deg > cfg_lo) begin
                        target_deg = target_deg - 1'b1;
                    end
                end
            end else if (press_age >= cfg_lockout) begin
                armed = 1'b1;
            end
        end
        r.heater = (climate == MODE_HEAT);
        r.fan = (climate == MODE_FAN);
        r.uv = lamp;
        r.mode = climate;
        r.target = target_deg;
        r.held = latched_temp;
        return r;
    endfunction

    function automatic t_tick make_tick(logic setting, logic up, logic down, logic uv_sw,
                                        int temp, t_uv_cmd cmd);
        t_tick w;
        w.setting = setting;
        w.up = up;
        w.down = down;
        w.uv_sw = uv_sw;
        w.temp = temp[TEMP_W-1:0];
        w.cmd = cmd;
        return w;
    endfunction

    // temperatures cluster around the band edges and the danger level
    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int span;
        int t;
        span = int'(cfg_band) + 48;
        case ($urandom_range(7))
            0, 1, 2, 3: t = int'(target_deg) * 16 + int'($urandom_range(2 * span)) - span;
            4: t = int'(cfg_danger) + int'($urandom_range(8)) - 4;
            5: t = $urandom_range(1) ? 2400 : -800;
            default: t = int'($urandom_range(3200)) - 800;
        endcase
        if (t < -800) t = -800;
        if (t > 2400) t = 2400;
        return t[TEMP_W-1:0];
    endfunction

    // mode switch stays put for stretches so both timers get to run
    function automatic t_tick random_tick();
        t_tick w;
        if ($urandom_range(99) < 8) gen_setting = !gen_setting;
        w.setting = gen_setting;
        w.up = ($urandom_range(99) < 35);
        w.down = ($urandom_range(99) < 35);
        w.uv_sw = 1'($urandom_range(1));
        w.temp = pick_temperature();
        w.cmd = ($urandom_range(99) < 70) ? UV_CMD_NONE : t_uv_cmd'($urandom_range(1, 3));
        return w;
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_word(input t_tick w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.in_setting_mode = w.setting;
        in_ch.up_pressed = w.up;
        in_ch.down_pressed = w.down;
        in_ch.uv_switch = w.uv_sw;
        in_ch.temperature = w.temp;
        in_ch.func = w.cmd;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        awaited_drive.push_back(climate_step(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    // nothing in flight before a register write
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (awaited_drive.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[CFG_DATA_W-1:0];
        case (idx)
            CFG_TARGET_LOW:  cfg_lo = value[DEG_W-1:0];
            CFG_TARGET_HIGH: cfg_hi = value[DEG_W-1:0];
            CFG_DANGER:      cfg_danger = value[TEMP_W-1:0];
            CFG_DEAD_BAND:   cfg_band = value[BAND_W-1:0];
            CFG_PERIOD:      cfg_period = value[TICK_W-1:0];
            CFG_LOCKOUT:     cfg_lockout = value[TICK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_config(input int lo, input int hi, input int danger, input int band,
                                input int period, input int lockout);
        wait_idle();
        write_reg(CFG_TARGET_LOW, lo);
        write_reg(CFG_TARGET_HIGH, hi);
        write_reg(CFG_DANGER, danger);
        write_reg(CFG_DEAD_BAND, band);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_LOCKOUT, lockout);
    endtask

    // reset defaults: period far away, so only the uv path moves
    task automatic test_reset_state();
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 0, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 0, UV_CMD_ON));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 0, UV_CMD_OFF));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 0, UV_CMD_TOGGLE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 0, UV_CMD_TOGGLE));
        // lamp still follows the remote flag on a setting tick, then remote drops
        send_word(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 0, UV_CMD_ON));
        send_word(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 0, UV_CMD_NONE));
    endtask

    // decision every tick, walk the temperature across every threshold
    task automatic test_thresholds();
        apply_config(20, 35, 640, 16, 1, 0);
        // first operating tick only arms the timer
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 641, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 640, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 417, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 416, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 384, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 385, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 416, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b0, -800, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 2400, UV_CMD_NONE));
    endtask

    // heater and fan keep the last mode while the target is stepped
    task automatic test_buttons();
        send_word(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b1, 1'b1, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 0, UV_CMD_NONE));
    endtask

    // chunks of random ticks, settings rerolled in between
    task automatic test_random_ticks(input int send_pct, input int recv_pct);
        int lo;
        int hi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < CHUNKS; c++) begin
            case (c)
                0: apply_config(0, 100, -800, 255, 1, 0);
                1: apply_config(100, 100, 2400, 0, 2, 1);
                2: apply_config(0, 0, int'($urandom_range(3200)) - 800, $urandom_range(255),
                                3, 2);
                default: begin
                    lo = $urandom_range(60);
                    hi = ($urandom_range(4) == 0) ? $urandom_range(100) : $urandom_range(100, lo);
                    apply_config(lo, hi, int'($urandom_range(3200)) - 800,
                                 $urandom_range(1) ? $urandom_range(40) : $urandom_range(255),
                                 $urandom_range(1, 8), $urandom_range(6));
                end
            endcase
            repeat (CHUNK_WORDS) send_word(random_tick());
        end
    endtask

    // largest period and lockout: no decision and no re-arm within a short run
    task automatic test_counter_saturation();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(20, 35, 640, 16, 1, 0);
        send_word(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 0, UV_CMD_NONE));
        apply_config(20, 35, 640, 16, 65535, 65535);
        send_word(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 0, UV_CMD_NONE));
        repeat (LONG_RUN) send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 300, UV_CMD_NONE));
        send_word(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 700, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 0, UV_CMD_NONE));
        send_word(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 0, UV_CMD_NONE));
    endtask

    // result side stalls at random, decided at each falling edge
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin : check_word
            t_drive want;
            if (awaited_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word at cycle %0d", cycle_count);
            end else begin
                want = awaited_drive.pop_front();
                words_checked++;
                if (out_ch.heater_on !== want.heater || out_ch.fan_on !== want.fan ||
                    out_ch.uv_on !== want.uv || out_ch.climate_mode !== want.mode ||
                    out_ch.target_degrees !== want.target ||
                    out_ch.last_temperature !== want.held ||
                    out_ch.decided !== want.decided) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("word %0d: expected heat %0b fan %0b uv %0b mode %0d target %0d temp %0d decided %0b",
                                 words_checked, want.heater, want.fan, want.uv, want.mode,
                                 want.target, want.held, want.decided);
                        $display("word %0d: got heat %0b fan %0b uv %0b mode %0d target %0d temp %0d decided %0b",
                                 words_checked, out_ch.heater_on, out_ch.fan_on, out_ch.uv_on,
                                 out_ch.climate_mode, out_ch.target_degrees,
                                 out_ch.last_temperature, out_ch.decided);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.in_setting_mode = 1'b0;
        in_ch.up_pressed = 1'b0;
        in_ch.down_pressed = 1'b0;
        in_ch.uv_switch = 1'b0;
        in_ch.temperature = '0;
        in_ch.func = UV_CMD_NONE;
        reset_thermostat();
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_thresholds();
        test_buttons();
        test_random_ticks(19, 80);
        test_random_ticks(80, 19);
        test_random_ticks(0, 0);
        test_counter_saturation();

        // drain the pipe and give stray words a chance to show up
        in_ch.valid = 1'b0;
        while (awaited_drive.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d tick words (%0d checked): %0d thermostat decisions, %0d presses",
                 words_sent, words_checked, decisions_made, presses_taken);
        $display("%0d remote uv commands over three idle mixes and a long-limit run",
                 uv_commands);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
